### rtl/des_pkg.sv
// Package for the delayed event slot bank: widths, function codes and shared types.
package des_pkg;

    localparam int SLOTS_DEF = 8;
    localparam int FUNC_W    = 2;
    localparam int MS_W      = 16;
    localparam int TAG_W     = 16;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ENQUEUE = 2'd0,
        FUNC_TICK    = 2'd1,
        FUNC_CLEAR   = 2'd2
    } t_func;

    typedef struct packed {
        logic            gt;
        logic [MS_W-1:0] diff;
    } t_alu_res;

endpackage

### rtl/des_channels.sv
// Valid/ready channel interfaces for the input items and the dispatched events.
interface des_in_if import des_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [MS_W-1:0]   delay_ms;
    logic [TAG_W-1:0]  event_tag;
    logic [MS_W-1:0]   elapsed_ms;

    modport source (output valid, func, delay_ms, event_tag, elapsed_ms, input ready);
    modport sink   (input valid, func, delay_ms, event_tag, elapsed_ms, output ready);
endinterface

interface des_out_if import des_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TAG_W-1:0] out_tag;
    logic             immediate;
    logic             last;

    modport source (output valid, out_tag, immediate, last, input ready);
    modport sink   (input valid, out_tag, immediate, last, output ready);
endinterface

### rtl/des_alu.sv
// Shared compare/subtract unit: checks a slot's time left against the elapsed time.
module des_alu import des_pkg::*; (
    input  logic [MS_W-1:0] i_remain,
    input  logic [MS_W-1:0] i_elapsed,
    output t_alu_res        o_res
);

    assign o_res.gt   = i_remain > i_elapsed;
    assign o_res.diff = i_remain - i_elapsed;

endmodule

### rtl/delayed_event_slots.sv
// Top level of the delayed event slot bank: sequencer, slot storage and output register.
//
// An enqueue into a free slot, a clear and unused codes leave the state idle. A
// tick is accepted and then walks the slots one per cycle, unless stalled, through
// a single compare/subtract unit. When any slot expires, a flush state then sends
// the final expiry marked last. An expiry found while an earlier one is still pending
// and the output register is full stalls the walk until that transfer completes.
// An immediate dispatch (zero delay or all slots busy) also passes through the
// flush state, unlike an enqueue. The final dispatch of any item also waits
// while the output register is full. The input is not ready while a tick scan
// or a final dispatch is in progress; a finished result may sit in the output
// register while the next item is taken.
module delayed_event_slots import des_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    des_in_if.sink    i_in,
    des_out_if.source o_out
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } t_state;

    t_state           r_state;
    logic [SLOTS-1:0] r_busy;
    logic [MS_W-1:0]  r_remain [SLOTS];
    logic [TAG_W-1:0] r_tag    [SLOTS];
    logic [IDX_W-1:0] r_idx;
    logic [MS_W-1:0]  r_elapsed;

    logic             r_pend_valid;
    logic [TAG_W-1:0] r_pend_tag;
    logic             r_pend_imm;

    logic             r_out_valid;
    logic [TAG_W-1:0] r_out_tag;
    logic             r_out_imm;
    logic             r_out_last;

    logic             w_in_xfer;
    logic             w_out_free;
    logic             w_out_load;
    logic             w_any_free;
    logic [IDX_W-1:0] w_free_idx;
    logic             w_expire;
    logic             w_scan_stall;
    t_alu_res         w_alu;

    des_alu u_alu (
        .i_remain  (r_remain[r_idx]),
        .i_elapsed (r_elapsed),
        .o_res     (w_alu)
    );

    always_comb begin
        w_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_busy[i]) begin
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_any_free   = ~&r_busy;
    assign i_in.ready   = (r_state == S_IDLE) && !r_pend_valid;
    assign w_in_xfer    = i_in.valid && i_in.ready;
    assign w_out_free   = !r_out_valid || o_out.ready;
    assign w_expire     = r_busy[r_idx] && !w_alu.gt;
    assign w_scan_stall = w_expire && r_pend_valid && !w_out_free;
    assign w_out_load   = ((r_state == S_SCAN) && w_expire && r_pend_valid && w_out_free)
                          || ((r_state == S_FLUSH) && w_out_free);

    assign o_out.valid     = r_out_valid;
    assign o_out.out_tag   = r_out_tag;
    assign o_out.immediate = r_out_imm;
    assign o_out.last      = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_busy       <= '0;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_xfer) begin
                        case (t_func'(i_in.func))
                            FUNC_ENQUEUE: begin
                                if ((i_in.delay_ms != '0) && w_any_free) begin
                                    r_busy[w_free_idx]   <= 1'b1;
                                    r_remain[w_free_idx] <= i_in.delay_ms;
                                    r_tag[w_free_idx]    <= i_in.event_tag;
                                end else begin
                                    r_pend_valid <= 1'b1;
                                    r_pend_tag   <= i_in.event_tag;
                                    r_pend_imm   <= 1'b1;
                                    r_state      <= S_FLUSH;
                                end
                            end
                            FUNC_TICK: begin
                                r_elapsed <= i_in.elapsed_ms;
                                r_idx     <= '0;
                                r_state   <= S_SCAN;
                            end
                            FUNC_CLEAR: begin
                                r_busy <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (!w_scan_stall) begin
                        if (r_busy[r_idx]) begin
                            if (w_alu.gt) begin
                                r_remain[r_idx] <= w_alu.diff;
                            end else begin
                                r_busy[r_idx] <= 1'b0;
                                // earlier expiry is known not to be last
                                if (r_pend_valid) begin
                                    r_out_tag   <= r_pend_tag;
                                    r_out_imm   <= r_pend_imm;
                                    r_out_last  <= 1'b0;
                                end
                                r_pend_valid <= 1'b1;
                                r_pend_tag   <= r_tag[r_idx];
                                r_pend_imm   <= 1'b0;
                            end
                        end
                        if (r_idx == LAST_IDX) begin
                            r_state <= (w_expire || r_pend_valid) ? S_FLUSH : S_IDLE;
                        end else begin
                            r_idx <= r_idx + IDX_W'(1);
                        end
                    end
                end
                S_FLUSH: begin
                    if (w_out_free) begin
                        r_out_tag    <= r_pend_tag;
                        r_out_imm    <= r_pend_imm;
                        r_out_last   <= 1'b1;
                        r_pend_valid <= 1'b0;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending dispatch left behind in idle");

    a_immediate_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_imm) |-> r_out_last)
        else $error("immediate dispatch not marked last");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_in.func == FUNC_CLEAR)) |=> (r_busy == '0))
        else $error("slots busy after clear");

    a_enqueue_takes_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && (i_in.func == FUNC_ENQUEUE) && (i_in.delay_ms != '0) && w_any_free)
        |=> ($countones(r_busy) == ($countones($past(r_busy)) + 1)))
        else $error("enqueue did not fill exactly one slot");

    a_scan_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (!i_in.ready && (r_idx <= LAST_IDX)))
        else $error("input taken or index out of range during scan");
`endif

endmodule
